// File: hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

  // Default operand width and fixed field widths
  localparam int OPERAND_BITS_DEF = 16;
  localparam int REQ_W            = 3;
  localparam int NUM_W            = 33;
  localparam int DEN_W            = 32;

  // Request codes
  localparam logic [REQ_W-1:0] OP_ADD  = 3'd0;
  localparam logic [REQ_W-1:0] OP_SUB  = 3'd1;
  localparam logic [REQ_W-1:0] OP_MUL  = 3'd2;
  localparam logic [REQ_W-1:0] OP_DIV  = 3'd3;
  localparam logic [REQ_W-1:0] OP_SIMP = 3'd4;
  localparam logic [REQ_W-1:0] OP_FMT  = 3'd5;
  localparam logic [REQ_W-1:0] OP_EQ   = 3'd6;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// File: hw/rtl/rau_in_if.sv
`timescale 1ns / 1ps

interface rau_in_if #(
  parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [rau_pkg::REQ_W-1:0]      req_type;
  logic signed [OPERAND_BITS-1:0] a_num;
  logic signed [OPERAND_BITS-1:0] a_den;
  logic signed [OPERAND_BITS-1:0] b_num;
  logic signed [OPERAND_BITS-1:0] b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

// File: hw/rtl/rau_out_if.sv
`timescale 1ns / 1ps

interface rau_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rau_pkg::NUM_W-1:0] res_num;
  logic signed [rau_pkg::DEN_W-1:0] res_den;
  logic                             is_equal;
  logic                             zero_gcd_error;

  modport source (output valid, res_num, res_den, is_equal, zero_gcd_error, input ready);
  modport sink (input valid, res_num, res_den, is_equal, zero_gcd_error, output ready);
endinterface

// File: hw/rtl/rational_arith_unit.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake     | Word
// ---------+-----+---------------+------------------------------------------
// in_ch    | in  | valid/ready   | req_type, a_num, a_den, b_num, b_den
// out_ch   | out | valid/ready   | res_num, res_den, is_equal, zero_gcd_error
//
// One word at a time; ready only while idle. add/sub/mul/div: the shared multiplier
// forms three products (the second is zero for mul and div), then finish and idle.
// simplify and format: binary gcd, one shift or subtract a cycle, then two restoring
// divisions by the gcd (skipped for 0/0); equal does both sides.
// Synchronous rst_n clears sequencer and output valid.
// A finished word waits in the output register; only a full one stalls.

module rational_arith_unit #(
  parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  localparam int W  = OPERAND_BITS;
  localparam int CW = $clog2(W);

  // Magnitude of a two's complement operand, fits W bits unsigned
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    logic [W-1:0] m;
    m = x[W-1] ? W'(-x) : W'(x);
    return m;
  endfunction

  // Sequencer and operands
  rau_pkg::state_t             state_r, state_nxt;
  logic [rau_pkg::REQ_W-1:0]   op_r, op_nxt;
  logic signed [W-1:0]         an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [1:0]                  step_r, step_nxt;
  logic                        side_r, side_nxt;

  // Arithmetic state
  logic signed [2*W-1:0]       prod_r, prod_nxt;
  logic signed [rau_pkg::NUM_W-1:0] num_acc_r, num_acc_nxt;
  logic signed [rau_pkg::DEN_W-1:0] den_acc_r, den_acc_nxt;
  logic                        eq_r, eq_nxt, err_r, err_nxt;
  logic [W-1:0]                u_r, u_nxt, v_r, v_nxt, g_r, g_nxt;
  logic [CW-1:0]               k_r, k_nxt, cnt_r, cnt_nxt;
  logic [W-1:0]                quo_r, quo_nxt, rem_r, rem_nxt;
  logic                        dsel_r, dsel_nxt;
  logic signed [W:0]           rn_r, rn_nxt, ra_num_r, ra_num_nxt, ra_den_r, ra_den_nxt;

  // Output register
  logic                             out_valid_r;
  logic signed [rau_pkg::NUM_W-1:0] o_num_r;
  logic signed [rau_pkg::DEN_W-1:0] o_den_r;
  logic                             o_eq_r, o_err_r;

  // Combinational helpers
  logic                  accept, out_free, more_side;
  logic signed [W-1:0]   sel_n, sel_d, mx, my;
  logic [W-1:0]          mag_n, mag_d, g_now;
  logic signed [2*W-1:0] prod;
  logic                  gcd_done;
  logic [W:0]            trial;
  logic                  fits, div_last, div_neg;
  logic [W-1:0]          rem_step, quo_step;
  logic signed [W:0]     div_val, fin_num, fin_den;
  logic                  side_done, fmt_neg;

  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign more_side = (op_r == rau_pkg::OP_EQ) && !side_r;

  // Fraction under reduction
  assign sel_n = side_r ? bn_r : an_r;
  assign sel_d = side_r ? bd_r : ad_r;
  assign mag_n = mag(sel_n);
  assign mag_d = mag(sel_d);

  // Shared multiplier operand select
  always_comb begin
    mx = '0;
    my = '0;
    case (step_r)
      2'd0: begin
        mx = an_r;
        my = (op_r == rau_pkg::OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mx = (op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV) ? '0 : bn_r;
        my = ad_r;
      end
      2'd2: begin
        mx = ad_r;
        my = (op_r == rau_pkg::OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end
  assign prod = (2*W)'(mx) * (2*W)'(my);

  // Binary gcd: finished once either side is zero
  assign gcd_done = (u_r == '0) || (v_r == '0);
  assign g_now    = (u_r | v_r) << k_r;

  // Restoring divider step
  assign trial    = {rem_r, quo_r[W-1]};
  assign fits     = trial >= {1'b0, g_r};
  assign rem_step = fits ? W'(trial - {1'b0, g_r}) : trial[W-1:0];
  assign quo_step = {quo_r[W-2:0], fits};
  assign div_last = cnt_r == CW'(W - 1);
  assign div_neg  = dsel_r ? sel_d[W-1] : sel_n[W-1];
  assign div_val  = div_neg ? -$signed({1'b0, quo_step}) : $signed({1'b0, quo_step});

  // One side's reduction complete (0/0 short-cuts straight from the gcd)
  assign side_done = ((state_r == rau_pkg::ST_GCD) && gcd_done && (g_now == '0)) ||
                     ((state_r == rau_pkg::ST_DIV) && div_last && dsel_r);
  assign fin_num   = (state_r == rau_pkg::ST_GCD) ? '0 : rn_r;
  assign fin_den   = (state_r == rau_pkg::ST_GCD) ? '0 : div_val;
  assign fmt_neg   = (op_r == rau_pkg::OP_FMT) && fin_den[W];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_ch.req_type)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB,
            rau_pkg::OP_MUL, rau_pkg::OP_DIV:  state_nxt = rau_pkg::ST_MUL;
            rau_pkg::OP_SIMP, rau_pkg::OP_FMT,
            rau_pkg::OP_EQ:                    state_nxt = rau_pkg::ST_LOAD;
            default:                           state_nxt = rau_pkg::ST_FIN;
          endcase
        end
      end
      rau_pkg::ST_MUL: begin
        if (step_r == 2'd3) state_nxt = rau_pkg::ST_FIN;
      end
      rau_pkg::ST_LOAD: state_nxt = rau_pkg::ST_GCD;
      rau_pkg::ST_GCD: begin
        if (gcd_done) begin
          if (g_now != '0)    state_nxt = rau_pkg::ST_DIV;
          else if (more_side) state_nxt = rau_pkg::ST_LOAD;
          else                state_nxt = rau_pkg::ST_FIN;
        end
      end
      rau_pkg::ST_DIV: begin
        if (div_last && dsel_r) state_nxt = more_side ? rau_pkg::ST_LOAD : rau_pkg::ST_FIN;
      end
      rau_pkg::ST_FIN: begin
        if (out_free) state_nxt = rau_pkg::ST_IDLE;
      end
      default: state_nxt = rau_pkg::ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    op_nxt      = op_r;
    an_nxt      = an_r;
    ad_nxt      = ad_r;
    bn_nxt      = bn_r;
    bd_nxt      = bd_r;
    step_nxt    = step_r;
    side_nxt    = side_r;
    prod_nxt    = prod_r;
    num_acc_nxt = num_acc_r;
    den_acc_nxt = den_acc_r;
    eq_nxt      = eq_r;
    err_nxt     = err_r;
    u_nxt       = u_r;
    v_nxt       = v_r;
    g_nxt       = g_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dsel_nxt    = dsel_r;
    rn_nxt      = rn_r;
    ra_num_nxt  = ra_num_r;
    ra_den_nxt  = ra_den_r;
    case (state_r)
      rau_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt      = in_ch.req_type;
          an_nxt      = in_ch.a_num;
          ad_nxt      = in_ch.a_den;
          bn_nxt      = in_ch.b_num;
          bd_nxt      = in_ch.b_den;
          step_nxt    = '0;
          side_nxt    = 1'b0;
          num_acc_nxt = '0;
          den_acc_nxt = '0;
          eq_nxt      = 1'b0;
          err_nxt     = 1'b0;
        end
      end
      // product of step n is consumed in step n+1
      rau_pkg::ST_MUL: begin
        prod_nxt = prod;
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd1: num_acc_nxt = rau_pkg::NUM_W'(prod_r);
          2'd2: num_acc_nxt = (op_r == rau_pkg::OP_SUB) ?
                              num_acc_r - rau_pkg::NUM_W'(prod_r) :
                              num_acc_r + rau_pkg::NUM_W'(prod_r);
          2'd3: den_acc_nxt = rau_pkg::DEN_W'(prod_r);
          default: ;
        endcase
      end
      rau_pkg::ST_LOAD: begin
        u_nxt = mag_n;
        v_nxt = mag_d;
        k_nxt = '0;
      end
      rau_pkg::ST_GCD: begin
        if (!gcd_done) begin
          if (!u_r[0] && !v_r[0]) begin
            u_nxt = u_r >> 1;
            v_nxt = v_r >> 1;
            k_nxt = k_r + CW'(1);
          end else if (!u_r[0]) begin
            u_nxt = u_r >> 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
          end else if (u_r >= v_r) begin
            u_nxt = u_r - v_r;
          end else begin
            v_nxt = v_r - u_r;
          end
        end else begin
          g_nxt    = g_now;
          quo_nxt  = mag_n;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          dsel_nxt = 1'b0;
          if (g_now == '0) err_nxt = 1'b1;
        end
      end
      rau_pkg::ST_DIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + CW'(1);
        if (div_last && !dsel_r) begin
          rn_nxt   = div_val;
          quo_nxt  = mag_d;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          dsel_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // reduced fraction ready: park side a, compare, or publish
    if (side_done) begin
      if (more_side) begin
        ra_num_nxt = fin_num;
        ra_den_nxt = fin_den;
        side_nxt   = 1'b1;
      end else if (op_r == rau_pkg::OP_EQ) begin
        eq_nxt = (ra_num_r == fin_num) && (ra_den_r == fin_den);
      end else begin
        num_acc_nxt = rau_pkg::NUM_W'(fmt_neg ? -fin_num : fin_num);
        den_acc_nxt = rau_pkg::DEN_W'(fmt_neg ? -fin_den : fin_den);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rau_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rau_pkg::ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)                      out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    bn_r      <= bn_nxt;
    bd_r      <= bd_nxt;
    step_r    <= step_nxt;
    side_r    <= side_nxt;
    prod_r    <= prod_nxt;
    num_acc_r <= num_acc_nxt;
    den_acc_r <= den_acc_nxt;
    eq_r      <= eq_nxt;
    err_r     <= err_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    g_r       <= g_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dsel_r    <= dsel_nxt;
    rn_r      <= rn_nxt;
    ra_num_r  <= ra_num_nxt;
    ra_den_r  <= ra_den_nxt;
    if (state_r == rau_pkg::ST_FIN && out_free) begin
      o_num_r <= num_acc_r;
      o_den_r <= den_acc_r;
      o_eq_r  <= eq_r;
      o_err_r <= err_r;
    end
  end

  // Ports
  assign in_ch.ready           = state_r == rau_pkg::ST_IDLE;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.res_num        = o_num_r;
  assign out_ch.res_den        = o_den_r;
  assign out_ch.is_equal       = o_eq_r;
  assign out_ch.zero_gcd_error = o_err_r;

`ifndef SYNTHESIS
  // A new result only ever comes out of the finish state
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rau_pkg::ST_FIN))
    else $error("result valid without finish state");

  // Accepted word starts the sequencer on the next edge
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != rau_pkg::ST_IDLE)
    else $error("accepted word did not start work");

  // Divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rau_pkg::ST_DIV |-> g_r != '0)
    else $error("division by zero gcd");

  // A positive compare carries zero fraction fields
  a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_eq_r) |-> (o_num_r == '0 && o_den_r == '0))
    else $error("equal result with nonzero fraction");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int OB           = rau_pkg::OPERAND_BITS_DEF;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int RAND_WORDS   = 1376;

  // Code the block must answer with an all-zero word
  localparam logic [rau_pkg::REQ_W-1:0] OP_NONE = 3'd7;

  localparam logic signed [OB-1:0] MAXV = {1'b0, {(OB-1){1'b1}}};
  localparam logic signed [OB-1:0] MINV = {1'b1, {(OB-1){1'b0}}};

  typedef struct {
    logic [rau_pkg::REQ_W-1:0] op;
    logic signed [OB-1:0]      a_num;
    logic signed [OB-1:0]      a_den;
    logic signed [OB-1:0]      b_num;
    logic signed [OB-1:0]      b_den;
  } rau_req_t;

  typedef struct {
    logic signed [rau_pkg::NUM_W-1:0] num;
    logic signed [rau_pkg::DEN_W-1:0] den;
    logic                             is_equal;
    logic                             zero_err;
  } rau_res_t;

  typedef struct {
    longint num;
    longint den;
    bit     err;
  } frac_t;

  // Predicts each result word and checks the block's words in order
  class fraction_checker;
    rau_res_t expected_q[$];
    int mismatches;
    int checked;
    int op_seen[8];
    int err_seen;
    int eq_seen;

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Divide both parts by the gcd of the magnitudes; 0/0 has no gcd
    function frac_t reduce_frac(longint n, longint d);
      longint unsigned x, y, t;
      longint g;
      frac_t f;
      x = (n < 0) ? -n : n;
      y = (d < 0) ? -d : d;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      g = x;
      if (g == 0) begin
        f.num = 0;
        f.den = 0;
        f.err = 1'b1;
      end else begin
        f.num = n / g;
        f.den = d / g;
        f.err = 1'b0;
      end
      return f;
    endfunction

    function rau_res_t predict_fraction(rau_req_t r);
      longint an, ad, bn, bd, rn, rd;
      frac_t fa, fb;
      rau_res_t res;
      an = r.a_num;
      ad = r.a_den;
      bn = r.b_num;
      bd = r.b_den;
      rn = 0;
      rd = 0;
      res.is_equal = 1'b0;
      res.zero_err = 1'b0;
      case (r.op)
        rau_pkg::OP_ADD: begin
          rn = an * bd + bn * ad;
          rd = ad * bd;
        end
        rau_pkg::OP_SUB: begin
          rn = an * bd - bn * ad;
          rd = ad * bd;
        end
        rau_pkg::OP_MUL: begin
          rn = an * bn;
          rd = ad * bd;
        end
        rau_pkg::OP_DIV: begin
          rn = an * bd;
          rd = ad * bn;
        end
        rau_pkg::OP_SIMP, rau_pkg::OP_FMT: begin
          fa = reduce_frac(an, ad);
          // format puts a negative sign on the numerator
          if (r.op == rau_pkg::OP_FMT && fa.den < 0) begin
            fa.num = -fa.num;
            fa.den = -fa.den;
          end
          rn = fa.num;
          rd = fa.den;
          res.zero_err = fa.err;
        end
        rau_pkg::OP_EQ: begin
          fa = reduce_frac(an, ad);
          fb = reduce_frac(bn, bd);
          res.is_equal = (fa.num == fb.num) && (fa.den == fb.den);
          res.zero_err = fa.err || fb.err;
        end
        default: ;
      endcase
      res.num = rau_pkg::NUM_W'(rn);
      res.den = rau_pkg::DEN_W'(rd);
      return res;
    endfunction

    function void note_input(rau_req_t r);
      expected_q.push_back(predict_fraction(r));
      op_seen[r.op]++;
    endfunction

    task check_result(rau_res_t got);
      rau_res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.num !== want.num)
        report_mismatch($sformatf("res_num %0d, want %0d", got.num, want.num));
      if (got.den !== want.den)
        report_mismatch($sformatf("res_den %0d, want %0d", got.den, want.den));
      if (got.is_equal !== want.is_equal)
        report_mismatch($sformatf("is_equal %b, want %b", got.is_equal, want.is_equal));
      if (got.zero_err !== want.zero_err)
        report_mismatch($sformatf("zero_gcd_error %b, want %b", got.zero_err, want.zero_err));
      if (got.zero_err === 1'b1) err_seen++;
      if (got.is_equal === 1'b1) eq_seen++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  rau_in_if #(.OPERAND_BITS(OB)) in_ch();
  rau_out_if out_ch();

  rational_arith_unit #(.OPERAND_BITS(OB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fraction_checker frac_chk = new;

  int src_idle_pct = 10;
  int snk_idle_pct = 68;
  int phase = 1;
  int words_sent = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("timeout with %0d words outstanding", frac_chk.expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one word, with random idle cycles ahead of it
  task automatic send_word(input rau_req_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= w.op;
    in_ch.a_num    <= w.a_num;
    in_ch.a_den    <= w.a_den;
    in_ch.b_num    <= w.b_num;
    in_ch.b_den    <= w.b_den;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    frac_chk.note_input(w);
    words_sent++;
  endtask

  task automatic send_fields(input logic [rau_pkg::REQ_W-1:0] op,
                             input logic signed [OB-1:0] an, ad, bn, bd);
    rau_req_t w;
    w.op    = op;
    w.a_num = an;
    w.a_den = ad;
    w.b_num = bn;
    w.b_den = bd;
    send_word(w);
  endtask

  // Zero, extremes and small values often; full-range values otherwise
  function automatic logic signed [OB-1:0] pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: begin
        case ($urandom_range(3))
          0: return MINV;
          1: return MAXV;
          2: return '1;
          default: return OB'(1);
        endcase
      end
      2, 3, 4: return OB'(int'($urandom_range(40)) - 20);
      default: return OB'($urandom());
    endcase
  endfunction

  function automatic rau_req_t random_req();
    rau_req_t w;
    int p, q, k;
    w.op    = ($urandom_range(59) == 0) ? OP_NONE : rau_pkg::REQ_W'($urandom_range(6));
    w.a_num = pick_operand();
    w.a_den = pick_operand();
    w.b_num = pick_operand();
    w.b_den = pick_operand();
    // reducing ops: half the time give a a common factor, and for equal
    // make b a rescaled copy of a, sometimes with both signs flipped
    if (w.op >= rau_pkg::OP_SIMP && w.op != OP_NONE && $urandom_range(1)) begin
      p = int'($urandom_range(200)) - 100;
      q = int'($urandom_range(200)) - 100;
      k = $urandom_range(300, 1);
      w.a_num = OB'(p * k);
      w.a_den = OB'(q * k);
      if (w.op == rau_pkg::OP_EQ) begin
        k = $urandom_range(300, 1);
        if ($urandom_range(3) == 0) k = -k;
        w.b_num = OB'(p * k);
        w.b_den = OB'(q * k);
      end
    end
    return w;
  endfunction

  // Result side: check accepted words, randomize ready, one long hold
  initial begin
    int hold_left;
    bit hold_done;
    rau_res_t got;
    hold_left = 0;
    hold_done = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.num      = out_ch.res_num;
        got.den      = out_ch.res_den;
        got.is_equal = out_ch.is_equal;
        got.zero_err = out_ch.zero_gcd_error;
        frac_chk.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && phase == 3) begin
        // block the output while the sender keeps pushing
        hold_done = 1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Reset and stimulus
  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= '0;
    in_ch.a_num    <= '0;
    in_ch.a_den    <= '0;
    in_ch.b_num    <= '0;
    in_ch.b_den    <= '0;
    out_ch.ready   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every op, zero over zero, sign handling
    send_fields(rau_pkg::OP_ADD,  MAXV, MINV, MINV, MAXV);
    send_fields(rau_pkg::OP_ADD,  MINV, MINV, MINV, MINV);
    send_fields(rau_pkg::OP_SUB,  MAXV, MINV, MINV, MINV);
    send_fields(rau_pkg::OP_SUB,  MINV, 1, MAXV, MINV);
    send_fields(rau_pkg::OP_MUL,  MINV, MINV, MINV, MINV);
    send_fields(rau_pkg::OP_MUL,  0, 0, 0, 0);
    send_fields(rau_pkg::OP_DIV,  MAXV, -1, MINV, MAXV);
    send_fields(rau_pkg::OP_DIV,  1, MINV, 0, MINV);
    send_fields(rau_pkg::OP_SIMP, 0, 0, MAXV, MINV);
    send_fields(rau_pkg::OP_SIMP, 0, -5, 0, 0);
    send_fields(rau_pkg::OP_SIMP, 0, 7, 0, 0);
    send_fields(rau_pkg::OP_SIMP, 6, -4, 0, 0);
    send_fields(rau_pkg::OP_SIMP, MINV, MINV, 0, 0);
    send_fields(rau_pkg::OP_SIMP, 5, 0, 0, 0);
    send_fields(rau_pkg::OP_FMT,  6, -4, 0, 0);
    send_fields(rau_pkg::OP_FMT,  MINV, -1, 0, 0);
    send_fields(rau_pkg::OP_FMT,  0, 0, 0, 0);
    send_fields(rau_pkg::OP_FMT,  0, -3, 0, 0);
    send_fields(rau_pkg::OP_EQ,   2, 4, -3, -6);
    send_fields(rau_pkg::OP_EQ,   3, 6, 1, 2);
    send_fields(rau_pkg::OP_EQ,   1, -2, -1, 2);
    send_fields(rau_pkg::OP_EQ,   0, 0, 0, 0);
    send_fields(rau_pkg::OP_EQ,   0, 0, 1, 2);
    send_fields(rau_pkg::OP_EQ,   MAXV, MINV, MAXV, MINV);
    send_fields(OP_NONE,          MINV, MAXV, MINV, MAXV);

    // Random words across three idle mixes
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == RAND_WORDS / 3) begin
        phase = 2;
        src_idle_pct = 68;
        snk_idle_pct = 10;
      end else if (i == 2 * RAND_WORDS / 3) begin
        phase = 3;
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      send_word(random_req());
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow for any late stray word
    while (frac_chk.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d words: add %0d sub %0d mul %0d div %0d",
             frac_chk.checked, frac_chk.op_seen[rau_pkg::OP_ADD],
             frac_chk.op_seen[rau_pkg::OP_SUB], frac_chk.op_seen[rau_pkg::OP_MUL],
             frac_chk.op_seen[rau_pkg::OP_DIV]);
    $display("simp %0d fmt %0d eq %0d bad op %0d; idle mixes 10/68, 68/10, none",
             frac_chk.op_seen[rau_pkg::OP_SIMP], frac_chk.op_seen[rau_pkg::OP_FMT],
             frac_chk.op_seen[rau_pkg::OP_EQ], frac_chk.op_seen[OP_NONE]);
    $display("one %0d-cycle output hold; %0d zero-gcd, %0d equal",
             HOLD_CYCLES, frac_chk.err_seen, frac_chk.eq_seen);
    if (frac_chk.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: rational_arith_unit.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_in_if.sv
hw/rtl/rau_out_if.sv
hw/rtl/rational_arith_unit.sv
tb/sv/tb.sv
